>>> src/remote_code_pulse_transmitter_unit_defines.svh
`ifndef REMOTE_CODE_PULSE_TRANSMITTER_UNIT_DEFINES_SVH
`define REMOTE_CODE_PULSE_TRANSMITTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RCPT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcpt port check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define RCPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcpt port check failed");

`endif

>>> src/rcpt_pkg.sv
`default_nettype none

package rcpt_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CODE_W = 24;
	localparam logic [4:0] SHORT_BITS = 5'd12;
	localparam logic [4:0] LONG_BITS = 5'd24;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_REPEAT = 2'd0;
	localparam logic [1:0] REG_GAP = 2'd1;
	localparam logic [1:0] REG_SHORT = 2'd2;
	localparam logic [1:0] REG_LONG = 2'd3;

	localparam logic [7:0] RESET_REPEAT = 8'd40;
	localparam logic [7:0] RESET_GAP = 8'd20;
	localparam logic [3:0] RESET_SHORT = 4'd1;
	localparam logic [3:0] RESET_LONG = 4'd2;

	typedef struct packed {
		logic fmt;
		logic [CODE_W-1:0] bits;
	} code_entry_t;

	typedef struct packed {
		logic is_enq;
		code_entry_t entry;
	} item_t;

	typedef struct packed {
		logic tx_level;
		logic busy_res;
		logic dropped;
	} result_t;

	typedef struct packed {
		logic [7:0] repeat_count;
		logic [7:0] gap_ticks;
		logic [3:0] short_ticks;
		logic [3:0] long_ticks;
	} cfg_t;

endpackage

`default_nettype wire

>>> src/rcpt_front.sv
`default_nettype none

module rcpt_front
	import rcpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic cmd,
	input wire logic [CODE_W-1:0] code_word,
	input wire logic short_format,
	output logic full,
	output logic item_valid,
	output item_t item,
	input wire logic take
);

	item_t ent_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic accept;
	item_t decoded;

	assign full = (cnt_q == 2'd2);
	assign accept = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign item = ent_q[rd_q];

	// classify: enqueue carries the code and its format, a tick carries nothing useful
	always_comb begin
		decoded.is_enq = cmd;
		decoded.entry.fmt = cmd & short_format;
		decoded.entry.bits = cmd ? code_word : '0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, take};
		end
	end

endmodule

`default_nettype wire

>>> src/rcpt_code_q.sv
`default_nettype none

module rcpt_code_q
	import rcpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire code_entry_t wr_data,
	input wire logic rd_en,
	output code_entry_t rd_data,
	output logic [QCNT_W-1:0] fill,
	output logic is_full
);

	code_entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QCNT_W-1:0] fill_q;

	localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);

	assign rd_data = mem_q[head_q];
	assign fill = fill_q;
	assign is_full = (fill_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[tail_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (wr_en) begin
				tail_q <= (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
			end
			if (rd_en) begin
				head_q <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
			end
			fill_q <= fill_q + QCNT_W'(wr_en) - QCNT_W'(rd_en);
		end
	end

endmodule

`default_nettype wire

>>> src/rcpt_back.sv
`default_nettype none

module rcpt_back
	import rcpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic item_valid,
	input wire item_t item,
	output logic take,
	input wire logic out_room,
	output result_t res
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_PRE = 3'd1;
	localparam logic [2:0] PH_BIT_A = 3'd2;
	localparam logic [2:0] PH_BIT_B = 3'd3;
	localparam logic [2:0] PH_END_HIGH = 3'd4;
	localparam logic [2:0] PH_GAP = 3'd5;

	code_entry_t code_q;
	logic [4:0] bit_q;
	logic [2:0] phase_q;
	logic [7:0] ticks_q;
	logic [7:0] reps_q;

	code_entry_t n_code;
	logic [4:0] n_bit;
	logic [2:0] n_ph;
	logic [7:0] n_tl;
	logic [7:0] n_rep;
	logic [4:0] nb;
	logic [7:0] r;
	logic lvl;
	logic drop;
	logic cq_wr;
	logic cq_rd;
	logic [QCNT_W-1:0] fill_after;

	code_entry_t cq_head;
	logic [QCNT_W-1:0] cq_fill;
	logic cq_full;

	function automatic logic cur_bit(input code_entry_t e, input logic [4:0] bi);
		logic [4:0] pos;
		begin
			// bytes go out low first, each msb first
			pos = bi ^ 5'd7;
			cur_bit = (pos <= 5'd23) ? e.bits[pos] : 1'b0;
		end
	endfunction

	function automatic logic level_of(input logic [2:0] ph, input logic fmt);
		begin
			case (ph)
				PH_PRE, PH_END_HIGH: level_of = 1'b1;
				PH_BIT_A: level_of = ~fmt;
				PH_BIT_B: level_of = fmt;
				default: level_of = 1'b0;
			endcase
		end
	endfunction

	function automatic logic [7:0] enter_ticks(input logic [2:0] ph, input code_entry_t e,
			input logic [4:0] bi, input cfg_t c);
		logic [7:0] s;
		logic [7:0] l;
		logic first_long;
		begin
			s = (c.short_ticks == 4'd0) ? 8'd1 : {4'd0, c.short_ticks};
			l = (c.long_ticks == 4'd0) ? 8'd1 : {4'd0, c.long_ticks};
			first_long = e.fmt ? ~cur_bit(e, bi) : cur_bit(e, bi);
			case (ph)
				PH_PRE, PH_END_HIGH: enter_ticks = s;
				PH_BIT_A: enter_ticks = first_long ? l : s;
				PH_BIT_B: enter_ticks = first_long ? s : l;
				PH_GAP: enter_ticks = (c.gap_ticks == 8'd0) ? 8'd1 : c.gap_ticks;
				default: enter_ticks = 8'd0;
			endcase
		end
	endfunction

	rcpt_code_q u_code_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cq_wr),
		.wr_data(item.entry),
		.rd_en(cq_rd),
		.rd_data(cq_head),
		.fill(cq_fill),
		.is_full(cq_full)
	);

	assign take = item_valid && out_room;

	always_comb begin
		n_code = code_q;
		n_bit = bit_q;
		n_ph = phase_q;
		n_tl = ticks_q;
		n_rep = reps_q;
		nb = '0;
		r = '0;
		lvl = 1'b0;
		drop = 1'b0;
		cq_wr = 1'b0;
		cq_rd = 1'b0;
		if (item.is_enq) begin
			lvl = level_of(phase_q, code_q.fmt);
			if (cq_full) begin
				drop = 1'b1;
			end else begin
				cq_wr = take;
			end
		end else begin
			// idle with a code waiting: this tick starts its first frame
			if (phase_q == PH_IDLE && cq_fill != '0) begin
				cq_rd = take;
				n_code = cq_head;
				n_rep = (cfg.repeat_count == 8'd0) ? 8'd1 : cfg.repeat_count;
				n_bit = 5'd0;
				n_ph = cq_head.fmt ? PH_PRE : PH_BIT_A;
				n_tl = enter_ticks(n_ph, n_code, n_bit, cfg);
			end
			if (n_ph != PH_IDLE) begin
				lvl = level_of(n_ph, n_code.fmt);
				n_tl = (n_tl != 8'd0) ? n_tl - 8'd1 : 8'd0;
				if (n_tl == 8'd0) begin
					case (n_ph)
						PH_PRE: begin
							n_ph = PH_BIT_A;
							n_tl = enter_ticks(n_ph, n_code, n_bit, cfg);
						end
						PH_BIT_A: begin
							n_ph = PH_BIT_B;
							n_tl = enter_ticks(n_ph, n_code, n_bit, cfg);
						end
						PH_BIT_B: begin
							nb = n_bit + 5'd1;
							n_bit = nb;
							if (nb >= (n_code.fmt ? SHORT_BITS : LONG_BITS)) begin
								n_ph = n_code.fmt ? PH_GAP : PH_END_HIGH;
							end else begin
								n_ph = PH_BIT_A;
							end
							n_tl = enter_ticks(n_ph, n_code, n_bit, cfg);
						end
						PH_END_HIGH: begin
							n_ph = PH_GAP;
							n_tl = enter_ticks(n_ph, n_code, n_bit, cfg);
						end
						PH_GAP: begin
							r = (n_rep != 8'd0) ? n_rep - 8'd1 : 8'd0;
							n_rep = r;
							if (r != 8'd0) begin
								n_bit = 5'd0;
								n_ph = n_code.fmt ? PH_PRE : PH_BIT_A;
								n_tl = enter_ticks(n_ph, n_code, n_bit, cfg);
							end else begin
								n_ph = PH_IDLE;
								n_tl = 8'd0;
								n_bit = 5'd0;
							end
						end
						default: begin
							n_ph = PH_IDLE;
						end
					endcase
				end
			end
		end
		fill_after = cq_fill + QCNT_W'(cq_wr) - QCNT_W'(cq_rd);
		res.tx_level = lvl;
		res.busy_res = (n_ph != PH_IDLE) || (fill_after != '0);
		res.dropped = drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			bit_q <= '0;
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			reps_q <= '0;
		end else if (take) begin
			code_q <= n_code;
			bit_q <= n_bit;
			phase_q <= n_ph;
			ticks_q <= n_tl;
			reps_q <= n_rep;
		end
	end

endmodule

`default_nettype wire

>>> src/rcpt_out_q.sv
`default_nettype none

module rcpt_out_q
	import rcpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire result_t wr_data,
	output logic room,
	input wire logic pop,
	output logic empty,
	output result_t rd_data
);

	result_t ent_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic rd_en;

	assign room = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd_en = pop && !empty;
	assign rd_data = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

`default_nettype wire

>>> src/remote_code_pulse_transmitter_unit.sv
// channel   direction  handshake             payload
// input     in         push / full           cmd, code_word, short_format
// result    out        empty / pop           tx_level, busy_res, dropped
// config    in         psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// one item per cycle sustained while the result queue has room; an item passes from the input
// queue through the waveform engine into the result queue, where its result shows
// the engine handles a tick or an enqueue combinationally as it is taken, including a code pop
// arst_n clears all control state; no clearing pass, code slots are written before read
// a stalled result side fills the two-entry result queue, then the input queue, then full

`default_nettype none

module remote_code_pulse_transmitter_unit
	import rcpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic cmd,
	input wire logic [CODE_W-1:0] code_word,
	input wire logic short_format,
	output logic empty,
	input wire logic pop,
	output logic tx_level,
	output logic busy_res,
	output logic dropped,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [APB_ADDR_W-1:0] paddr,
	input wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	logic [7:0] repeat_q;
	logic [7:0] gap_q;
	logic [3:0] short_q;
	logic [3:0] long_q;
	logic [1:0] reg_idx;
	logic cfg_wr;
	cfg_t cfg;

	logic item_valid;
	item_t item;
	logic take;
	logic out_room;
	result_t res;
	result_t out_res;

	assign pready = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= RESET_REPEAT;
			gap_q <= RESET_GAP;
			short_q <= RESET_SHORT;
			long_q <= RESET_LONG;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_REPEAT: repeat_q <= pwdata[7:0];
				REG_GAP: gap_q <= pwdata[7:0];
				REG_SHORT: short_q <= pwdata[3:0];
				REG_LONG: long_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_REPEAT: prdata = {24'd0, repeat_q};
			REG_GAP: prdata = {24'd0, gap_q};
			REG_SHORT: prdata = {28'd0, short_q};
			REG_LONG: prdata = {28'd0, long_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		cfg.repeat_count = repeat_q;
		cfg.gap_ticks = gap_q;
		cfg.short_ticks = short_q;
		cfg.long_ticks = long_q;
	end

	rcpt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.cmd(cmd),
		.code_word(code_word),
		.short_format(short_format),
		.full(full),
		.item_valid(item_valid),
		.item(item),
		.take(take)
	);

	rcpt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.item_valid(item_valid),
		.item(item),
		.take(take),
		.out_room(out_room),
		.res(res)
	);

	rcpt_out_q u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(take),
		.wr_data(res),
		.room(out_room),
		.pop(pop),
		.empty(empty),
		.rd_data(out_res)
	);

	assign tx_level = out_res.tx_level;
	assign busy_res = out_res.busy_res;
	assign dropped = out_res.dropped;

endmodule

`default_nettype wire

>>> src/rcpt_checker.sv
`default_nettype none

`include "remote_code_pulse_transmitter_unit_defines.svh"

module rcpt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic tx_level,
	input wire logic busy_res,
	input wire logic dropped
);

	// input side only backs up behind a waiting result
	`RCPT_ASSERT_NOW(a_full_needs_result, full, !empty)

	// a high line level never comes from an idle transmitter
	`RCPT_ASSERT_NOW(a_level_busy, !empty && tx_level, busy_res)

	// a refused code means the code queue was full, so still busy
	`RCPT_ASSERT_NOW(a_drop_busy, !empty && dropped, busy_res)

	`RCPT_ASSERT_NEXT(a_result_hold, !empty && !pop,
		!empty && $stable({tx_level, busy_res, dropped}))

endmodule

bind remote_code_pulse_transmitter_unit rcpt_checker u_rcpt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.full(full),
	.empty(empty),
	.pop(pop),
	.tx_level(tx_level),
	.busy_res(busy_res),
	.dropped(dropped)
);

`default_nettype wire
